### design/hnca_pkg.sv
`default_nettype none

package hnca_pkg;

   // Field widths fixed by the item layout.
   localparam int BASE_LEN  = 3;
   localparam int BASE_W    = 2;
   localparam int SEQ_W     = BASE_LEN * BASE_W;
   localparam int SLOT_W    = 3;
   localparam int DIST_W    = 2;
   localparam int CLUSTER_W = 3;
   localparam int COUNT_W   = 4;

   // Number of centroid slots, one cell each; the slot field addresses all of them.
   localparam int MAX_CENTROIDS = 8;

   // Function codes of an input transaction.
   localparam logic FUNC_LOAD      = 1'b0;
   localparam logic FUNC_CANDIDATE = 1'b1;

   // Centroid count after reset.
   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

   typedef struct packed {
      logic              func;
      logic [SLOT_W-1:0] slot_index;
      logic [SEQ_W-1:0]  sequence_req;
      logic              group_last;
   } req_type;

   typedef struct packed {
      logic [CLUSTER_W-1:0] cluster_index;
      logic [SEQ_W-1:0]     best_sequence;
      logic [DIST_W-1:0]    best_distance;
   } rsp_type;

   // What one cell hands to the next: the item and the best distance so far.
   typedef struct packed {
      logic              valid;
      req_type           item;
      logic [DIST_W-1:0] best_distance;
   } token_type;

   // Number of bases in which two codons differ.
   function automatic logic [DIST_W-1:0] hamming(input logic [SEQ_W-1:0] a,
                                                 input logic [SEQ_W-1:0] b);
      logic [DIST_W-1:0] d;
      d = '0;
      for (int i = 0; i < BASE_LEN; i++) begin
         if (a[i*BASE_W +: BASE_W] != b[i*BASE_W +: BASE_W]) begin
            d = d + DIST_W'(1);
         end
      end
      return d;
   endfunction

endpackage

`default_nettype wire

### design/hnca_cell.sv
`default_nettype none

module hnca_cell #(
   parameter int CELL_ID = 0,
   parameter int IDX_W   = 3
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic [hnca_pkg::COUNT_W-1:0]  count,
   input  wire hnca_pkg::token_type           tok_in,
   input  wire logic [IDX_W-1:0]              clu_in,
   output hnca_pkg::token_type                tok_out,
   output logic [IDX_W-1:0]                   clu_out
);

   logic [hnca_pkg::SEQ_W-1:0]  centroid_ff;
   hnca_pkg::token_type         tok_ff;
   hnca_pkg::token_type         tok_in_val;
   logic [IDX_W-1:0]            clu_ff;
   logic [IDX_W-1:0]            clu_in_val;
   logic [hnca_pkg::DIST_W-1:0] cell_distance;
   logic                        active;
   logic                        is_load;
   logic                        is_cand;

   // Slot zero is always compared; the others only below the active count.
   assign active  = (CELL_ID == 0) || (CELL_ID < int'(count));
   assign is_load = tok_in.valid && (tok_in.item.func == hnca_pkg::FUNC_LOAD) &&
                    (int'(tok_in.item.slot_index) == CELL_ID);
   assign is_cand = tok_in.valid && (tok_in.item.func == hnca_pkg::FUNC_CANDIDATE);
   assign cell_distance = hnca_pkg::hamming(tok_in.item.sequence_req, centroid_ff);

   // A strictly smaller distance takes over, so ties stay with the lower slot.
   always_comb begin
      tok_in_val = tok_in;
      clu_in_val = clu_in;
      if (is_cand && active &&
          ((CELL_ID == 0) || (cell_distance < tok_in.best_distance))) begin
         tok_in_val.best_distance = cell_distance;
         clu_in_val               = IDX_W'(CELL_ID);
      end
   end

   // Centroid slot owned by this cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         centroid_ff <= '0;
      end else if (advance && is_load) begin
         centroid_ff <= tok_in.item.sequence_req;
      end
   end

   // Hand the transaction to the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in_val;
         clu_ff <= clu_in_val;
      end
   end

   assign tok_out = tok_ff;
   assign clu_out = clu_ff;

endmodule

`default_nettype wire

### design/hnca_accum.sv
`default_nettype none

module hnca_accum #(
   parameter int IDX_W = 3
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire hnca_pkg::token_type  tail_tok,
   input  wire logic [IDX_W-1:0]     tail_clu,
   output logic                      advance,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output hnca_pkg::rsp_type         rsp_data
);

   logic                         run_valid_ff, run_valid_in;
   logic [hnca_pkg::DIST_W-1:0]  run_dist_ff, run_dist_in;
   logic [IDX_W-1:0]             run_clu_ff, run_clu_in;
   logic [hnca_pkg::SEQ_W-1:0]   run_seq_ff, run_seq_in;
   logic                         out_valid_ff, out_valid_in;
   hnca_pkg::rsp_type            out_ff, out_in;
   logic                         cand;
   logic                         emit;
   logic                         take;
   logic [hnca_pkg::DIST_W-1:0]  new_dist;
   logic [IDX_W-1:0]             new_clu;
   logic [hnca_pkg::SEQ_W-1:0]   new_seq;

   assign cand = tail_tok.valid && (tail_tok.item.func == hnca_pkg::FUNC_CANDIDATE);
   assign emit = cand && tail_tok.item.group_last;

   // The chain holds only when a result is due and the output is still occupied.
   assign advance = !(emit && out_valid_ff && !rsp_ready);

   // Earlier codon keeps a full tie.
   assign take = !run_valid_ff || (tail_tok.best_distance < run_dist_ff) ||
                 ((tail_tok.best_distance == run_dist_ff) && (tail_clu < run_clu_ff));
   assign new_dist = take ? tail_tok.best_distance : run_dist_ff;
   assign new_clu  = take ? tail_clu : run_clu_ff;
   assign new_seq  = take ? tail_tok.item.sequence_req : run_seq_ff;

   // Running best of the open group and the output register.
   always_comb begin
      run_valid_in = run_valid_ff;
      run_dist_in  = run_dist_ff;
      run_clu_in   = run_clu_ff;
      run_seq_in   = run_seq_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      if (advance && cand) begin
         if (emit) begin
            run_valid_in         = 1'b0;
            run_dist_in          = '0;
            run_clu_in           = '0;
            run_seq_in           = '0;
            out_valid_in         = 1'b1;
            out_in.cluster_index = hnca_pkg::CLUSTER_W'(new_clu);
            out_in.best_sequence = new_seq;
            out_in.best_distance = new_dist;
         end else begin
            run_valid_in = 1'b1;
            run_dist_in  = new_dist;
            run_clu_in   = new_clu;
            run_seq_in   = new_seq;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_valid_ff <= 1'b0;
         run_dist_ff  <= '0;
         run_clu_ff   <= '0;
         run_seq_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         run_valid_ff <= run_valid_in;
         run_dist_ff  <= run_dist_in;
         run_clu_ff   <= run_clu_in;
         run_seq_ff   <= run_seq_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

### design/hamming_nearest_centroid_assign.sv
// A candidate transaction is registered in each cell in turn, cell 0 capturing it at the edge
// that accepts it; a group's last candidate then sets the accumulator's output register, rsp_valid.
// Throughput: one transaction per cycle; the cell chain is a pipeline and stalls only
// when a group result is due while the output register still holds an untaken result.
// Reset clears all centroid slots to zero, the running best and the pipeline, and sets
// the centroid count to one.
`default_nettype none

module hamming_nearest_centroid_assign (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire hnca_pkg::req_type             req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output hnca_pkg::rsp_type                  rsp_data,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [hnca_pkg::COUNT_W-1:0]  csr_data
);

   localparam int MaxCentroids = hnca_pkg::MAX_CENTROIDS;
   localparam int IdxW = (MaxCentroids > 1) ? $clog2(MaxCentroids) : 1;

   logic [hnca_pkg::COUNT_W-1:0] count_ff;
   logic                         advance;
   hnca_pkg::token_type          tok [MaxCentroids+1];
   logic [IdxW-1:0]              clu [MaxCentroids+1];

   // Centroid count register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= hnca_pkg::COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         count_ff <= csr_data;
      end
   end

   // Head of the chain.
   assign req_ready              = advance;
   assign tok[0].valid           = req_valid && req_ready;
   assign tok[0].item            = req_data;
   assign tok[0].best_distance   = '0;
   assign clu[0]                 = '0;

   // One cell per centroid slot.
   for (genvar g = 0; g < MaxCentroids; g++) begin : g_cell
      hnca_cell #(
         .CELL_ID(g),
         .IDX_W  (IdxW)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .advance(advance),
         .count  (count_ff),
         .tok_in (tok[g]),
         .clu_in (clu[g]),
         .tok_out(tok[g+1]),
         .clu_out(clu[g+1])
      );
   end

   // Group minimum and result register.
   hnca_accum #(
      .IDX_W(IdxW)
   ) u_accum (
      .clock    (clock),
      .reset    (reset),
      .tail_tok (tok[MaxCentroids]),
      .tail_clu (clu[MaxCentroids]),
      .advance  (advance),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
